>>> hdl/qse_pkg.sv
// Shared types and constants of the quicksort engine.
`default_nettype none

package qse_pkg;

    localparam int MAX_ITEMS_DEFAULT = 64;
    localparam int VALUE_W           = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] in_value;
        logic                      in_last;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
        logic                      overflow;
    } out_word_t;

endpackage

`default_nettype wire

>>> hdl/qse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/qse_sorter.sv
// Hoare partition sequencer with its range stack, working on the value store.
`default_nettype none

module qse_sorter #(
    parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [$clog2(MAX_ITEMS):0]       count,
    output logic                                  done,
    output logic                                  st_we,
    output logic      [$clog2(MAX_ITEMS)-1:0]     st_waddr,
    output logic      [qse_pkg::VALUE_W-1:0]      st_wdata,
    output logic      [$clog2(MAX_ITEMS)-1:0]     st_raddr,
    input  wire logic [qse_pkg::VALUE_W-1:0]      st_rdata
);

    import qse_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = IDX_W + 1;
    localparam int POS_W = IDX_W + 2;
    localparam int STK_W = 2 * IDX_W;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_POP,
        S_PIVOT,
        S_LSCAN,
        S_RSCAN,
        S_SWAP,
        S_SPLIT
    } state_t;

    state_t             state_reg, state_next;
    pos_t               lo_reg, lo_next;
    pos_t               hi_reg, hi_next;
    pos_t               l_reg, l_next;
    pos_t               r_reg, r_next;
    logic [VALUE_W-1:0] pivot_reg, pivot_next;
    logic [VALUE_W-1:0] val_l_reg, val_l_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;

    logic               stk_we;
    logic [IDX_W-1:0]   stk_waddr;
    logic [STK_W-1:0]   stk_wdata;
    logic [IDX_W-1:0]   stk_raddr;
    logic [STK_W-1:0]   stk_rdata;

    pos_t               l_inc, r_dec, span, left_len, right_len;
    logic [CNT_W-1:0]   sp_dec;

    assign l_inc     = l_reg + pos_t'(1);
    assign r_dec     = r_reg - pos_t'(1);
    assign span      = hi_reg - lo_reg;
    assign left_len  = r_reg - lo_reg;
    assign right_len = hi_reg - l_reg;
    assign sp_dec    = sp_reg - CNT_W'(1);

    qse_ram #(
        .WIDTH (STK_W),
        .DEPTH (MAX_ITEMS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        pivot_next = pivot_reg;
        val_l_next = val_l_reg;
        sp_next    = sp_reg;
        done       = 1'b0;
        st_we      = 1'b0;
        st_waddr   = l_reg[IDX_W-1:0];
        st_wdata   = st_rdata;
        st_raddr   = l_reg[IDX_W-1:0];
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[IDX_W-1:0];
        stk_wdata  = {l_reg[IDX_W-1:0], hi_reg[IDX_W-1:0]};
        stk_raddr  = sp_dec[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = pos_t'({1'b0, count}) - pos_t'(1);
                    sp_next    = '0;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (span > pos_t'(0))
                begin
                    st_raddr   = hi_reg[IDX_W-1:0];
                    state_next = S_PIVOT;
                end
                else if (sp_reg != '0)
                begin
                    sp_next    = sp_dec;
                    state_next = S_POP;
                end
                else
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                lo_next    = pos_t'({2'b00, stk_rdata[STK_W-1:IDX_W]});
                hi_next    = pos_t'({2'b00, stk_rdata[IDX_W-1:0]});
                state_next = S_RANGE;
            end
            S_PIVOT:
            begin
                pivot_next = st_rdata;
                l_next     = lo_reg;
                r_next     = hi_reg;
                st_raddr   = lo_reg[IDX_W-1:0];
                state_next = S_LSCAN;
            end
            S_LSCAN:
            begin
                if ((l_reg < hi_reg) && ($signed(st_rdata) < $signed(pivot_reg)))
                begin
                    l_next   = l_inc;
                    st_raddr = l_inc[IDX_W-1:0];
                end
                else
                begin
                    val_l_next = st_rdata;
                    st_raddr   = r_reg[IDX_W-1:0];
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN:
            begin
                if ((r_reg > lo_reg) && ($signed(pivot_reg) < $signed(st_rdata)))
                begin
                    r_next   = r_dec;
                    st_raddr = r_dec[IDX_W-1:0];
                end
                else if (l_reg <= r_reg)
                begin
                    // First half of the exchange: the right value goes left.
                    st_we      = 1'b1;
                    st_waddr   = l_reg[IDX_W-1:0];
                    st_wdata   = st_rdata;
                    state_next = S_SWAP;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SWAP:
            begin
                st_we    = 1'b1;
                st_waddr = r_reg[IDX_W-1:0];
                st_wdata = val_l_reg;
                l_next   = l_inc;
                r_next   = r_dec;
                st_raddr = l_inc[IDX_W-1:0];
                if (l_inc <= r_dec)
                begin
                    state_next = S_LSCAN;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // The larger part is pushed, the smaller one is handled next.
                if (left_len < right_len)
                begin
                    if ((right_len > pos_t'(0)) && (sp_reg < CNT_W'(MAX_ITEMS)))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = {l_reg[IDX_W-1:0], hi_reg[IDX_W-1:0]};
                        sp_next   = sp_reg + CNT_W'(1);
                    end
                    hi_next = r_reg;
                end
                else
                begin
                    if ((left_len > pos_t'(0)) && (sp_reg < CNT_W'(MAX_ITEMS)))
                    begin
                        stk_we    = 1'b1;
                        stk_wdata = {lo_reg[IDX_W-1:0], r_reg[IDX_W-1:0]};
                        sp_next   = sp_reg + CNT_W'(1);
                    end
                    lo_next = l_reg;
                end
                state_next = S_RANGE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        pivot_reg <= pivot_next;
        val_l_reg <= val_l_next;
    end

endmodule

`default_nettype wire

>>> hdl/quicksort_engine_unit.sv
// Top level of the quicksort engine: loading, sort control and result output.
// Loading: words are taken while the block is in its load phase; the sort then
// runs in place, its pace bounded by the single read port of the value store.
// Output: each word is read from the store, then captured; result_stall holds it.
// Reset: rst_n clears the control state asynchronously; store contents are kept.
`default_nettype none

module quicksort_engine_unit #(
    parameter int MAX_ITEMS = qse_pkg::MAX_ITEMS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    output logic                    load_stall,
    input  wire qse_pkg::in_word_t  load_word,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output qse_pkg::out_word_t      result_word
);

    import qse_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = IDX_W + 1;

    // The block cycles through loading, sorting in place, and reading out.
    // Input words are refused while a set is being sorted or read out.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_OUT_RD,
        ST_OUT_CAP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             start_reg, start_next;
    logic             res_valid_reg, res_valid_next;
    out_word_t        res_word_reg, res_word_next;

    logic             load_accept;
    logic             store_room;
    logic             is_final;

    // Value store port, shared between the loader, the sorter and the readout.
    logic               store_we;
    logic [IDX_W-1:0]   store_waddr;
    logic [VALUE_W-1:0] store_wdata;
    logic [IDX_W-1:0]   store_raddr;
    logic [VALUE_W-1:0] store_rdata;

    logic               sort_done;
    logic               srt_we;
    logic [IDX_W-1:0]   srt_waddr;
    logic [VALUE_W-1:0] srt_wdata;
    logic [IDX_W-1:0]   srt_raddr;

    assign load_stall   = (state_reg != ST_LOAD);
    assign load_accept  = load_valid && !load_stall;
    assign store_room   = (count_reg < CNT_W'(MAX_ITEMS));
    assign is_final     = ({1'b0, k_reg} == (count_reg - CNT_W'(1)));
    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;

    qse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    qse_sorter #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .count    (count_reg),
        .done     (sort_done),
        .st_we    (srt_we),
        .st_waddr (srt_waddr),
        .st_wdata (srt_wdata),
        .st_raddr (srt_raddr),
        .st_rdata (store_rdata)
    );

    // The sorter owns the store port while sorting; otherwise the loader
    // writes at the fill count and the readout reads at its own index.
    always_comb
    begin
        if (state_reg == ST_SORT)
        begin
            store_we    = srt_we;
            store_waddr = srt_waddr;
            store_wdata = srt_wdata;
            store_raddr = srt_raddr;
        end
        else
        begin
            store_we    = load_accept && store_room;
            store_waddr = count_reg[IDX_W-1:0];
            store_wdata = load_word.in_value;
            store_raddr = k_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        start_next     = 1'b0;
        res_valid_next = res_valid_reg && result_stall;
        res_word_next  = res_word_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_accept)
                begin
                    // A word that finds the store full is dropped and flagged.
                    if (store_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (load_word.in_last)
                    begin
                        start_next = 1'b1;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                if (sort_done)
                begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                // Issue the read only once the output register is free
                // by the time the data comes back.
                if (!res_valid_reg || !result_stall)
                begin
                    state_next = ST_OUT_CAP;
                end
            end
            ST_OUT_CAP:
            begin
                res_valid_next          = 1'b1;
                res_word_next.out_value = store_rdata;
                res_word_next.out_last  = is_final;
                res_word_next.overflow  = ovf_reg;
                if (is_final)
                begin
                    // The set is done; the last word may still wait in the
                    // output register while the next set loads.
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    // A new result word appears only right after a store read was captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_OUT_CAP))
        else $error("result word raised outside the capture step");

    // The sorter reports completion only while the top level waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sort_done |-> (state_reg == ST_SORT))
        else $error("sort completion outside the sort phase");

    // The fill count never exceeds the store capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // The store is never written while it is being read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> ((state_reg == ST_LOAD) || (state_reg == ST_SORT)))
        else $error("store written during readout");

endmodule

`default_nettype wire
